[rtl/cse_pkg.sv]
package cse_pkg;

  // Index field of a queued job; wide enough for the largest supported table.
  localparam int IDX_W = 10;

  // Configuration address width: one register, one spare word above it.
  localparam int ADDR_W = 3;

  // Register index as decoded from the word address bit.
  localparam logic REG_SEG_COUNT = 1'b0;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [2:0] ORD_VALUE = 3'd0;
  localparam logic [2:0] ORD_D1    = 3'd1;
  localparam logic [2:0] ORD_D2    = 3'd2;
  localparam logic [2:0] ORD_D3    = 3'd3;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic               opcode;
    logic [6:0]         entry_index;
    logic signed [31:0] knot_position;
    logic signed [47:0] cubic_coeff;
    logic signed [47:0] square_coeff;
    logic signed [47:0] linear_coeff;
    logic signed [47:0] constant_coeff;
    logic signed [31:0] eval_position;
    logic [2:0]         deriv_order;
  } cse_in_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [5:0]         segment_used;
    logic               saturated;
  } cse_out_t;

  // Work handed from the knot search to the evaluation engine.
  typedef struct packed {
    logic               is_eval;
    logic [IDX_W-1:0]   index;
    logic signed [31:0] position;
    logic [2:0]         deriv_order;
    logic signed [47:0] cubic_coeff;
    logic signed [47:0] square_coeff;
    logic signed [47:0] linear_coeff;
    logic signed [47:0] constant_coeff;
  } cse_job_t;

endpackage

[rtl/cse_front.sv]
module cse_front #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cse_pkg::cse_in_t  cmd,
  output logic              busy,
  input  logic [6:0]        seg_count,
  output logic              job_push,
  output cse_pkg::cse_job_t job,
  input  logic              job_full
);
  import cse_pkg::*;

  localparam int KW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = $clog2(MAX_SEGMENTS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_PUSH   = 2'd2;

  logic [1:0]         state;
  logic [31:0]        cnt_ext;
  logic [31:0]        n_ext;
  logic [31:0]        idx_ext;
  logic [KW-1:0]      n;
  logic               accept;
  logic               knot_we;
  logic               coef_we;
  logic signed [31:0] knot_mem [MAX_SEGMENTS + 1];
  logic signed [31:0] knot_q;
  logic [KW-1:0]      addr;
  logic [KW-1:0]      chk_idx;
  logic               chk_vld;
  logic               hit;
  logic               last;
  logic [SW-1:0]      found_seg;
  cse_job_t           job_q;

  // Effective segment count: zero acts as one, the top is clamped to the table.
  always_comb begin
    cnt_ext = 32'(seg_count);
    if (cnt_ext == 32'd0) begin
      n_ext = 32'd1;
    end else if (cnt_ext > 32'(MAX_SEGMENTS)) begin
      n_ext = 32'(MAX_SEGMENTS);
    end else begin
      n_ext = cnt_ext;
    end
    n = KW'(n_ext);
  end

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign idx_ext = 32'(cmd.entry_index);
  assign knot_we = accept && (cmd.opcode == OP_LOAD) && (idx_ext <= 32'(MAX_SEGMENTS));
  assign coef_we = accept && (cmd.opcode == OP_LOAD) && (idx_ext < 32'(MAX_SEGMENTS))
                   && (idx_ext != n_ext);

  // The scan stops at the first knot above the point; with unsorted knots
  // that first hit still defines the segment.
  assign hit  = chk_vld && ($signed(knot_q) > $signed(job_q.position));
  assign last = chk_vld && (chk_idx == n);

  always_comb begin
    if (hit) begin
      found_seg = (chk_idx == '0) ? '0 : SW'(chk_idx - KW'(1));
    end else begin
      found_seg = SW'(n - KW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (knot_we) begin
      knot_mem[KW'(cmd.entry_index)] <= cmd.knot_position;
    end
    if (state == S_SEARCH) begin
      knot_q <= knot_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      addr    <= '0;
      chk_idx <= '0;
      chk_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr    <= '0;
            chk_vld <= 1'b0;
            if (cmd.opcode == OP_EVAL) begin
              state <= S_SEARCH;
            end else if (coef_we) begin
              state <= S_PUSH;
            end
          end
        end
        S_SEARCH: begin
          chk_idx <= addr;
          chk_vld <= !(hit || last);
          if (addr != n) begin
            addr <= addr + KW'(1);
          end
          if (hit || last) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!job_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_q.is_eval        <= (cmd.opcode == OP_EVAL);
      job_q.index          <= IDX_W'(cmd.entry_index);
      job_q.position       <= cmd.eval_position;
      job_q.deriv_order    <= cmd.deriv_order;
      job_q.cubic_coeff    <= cmd.cubic_coeff;
      job_q.square_coeff   <= cmd.square_coeff;
      job_q.linear_coeff   <= cmd.linear_coeff;
      job_q.constant_coeff <= cmd.constant_coeff;
    end else if ((state == S_SEARCH) && (hit || last)) begin
      job_q.index <= IDX_W'(found_seg);
    end
  end

  assign job_push = (state == S_PUSH) && !job_full;
  assign job      = job_q;

endmodule

[rtl/cse_queue.sv]
module cse_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cse_pkg::cse_job_t push_job,
  output logic              full,
  input  logic              pop,
  output cse_pkg::cse_job_t pop_job,
  output logic              empty
);
  import cse_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cse_job_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/cse_back.sv]
module cse_back #(
  parameter int MAX_SEGMENTS  = 64,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_empty,
  input  cse_pkg::cse_job_t job,
  output logic              job_pop,
  output logic              done,
  output cse_pkg::cse_out_t result
);
  import cse_pkg::*;

  localparam int SW = $clog2(MAX_SEGMENTS);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_INIT   = 3'd1;
  localparam logic [2:0] B_MUL_LO = 3'd2;
  localparam logic [2:0] B_MUL_HI = 3'd3;
  localparam logic [2:0] B_SUM    = 3'd4;
  localparam logic [2:0] B_ADD    = 3'd5;

  logic [2:0]         state;
  logic signed [47:0] cubic_mem    [MAX_SEGMENTS];
  logic signed [47:0] square_mem   [MAX_SEGMENTS];
  logic signed [47:0] linear_mem   [MAX_SEGMENTS];
  logic signed [47:0] constant_mem [MAX_SEGMENTS];
  logic signed [47:0] ca, cb, cc, cd;
  logic signed [31:0] x_q;
  logic [2:0]         order;
  logic [5:0]         seg_q;
  logic signed [63:0] a64, b64, c64, d64, a3, a6, b2;
  logic signed [63:0] init_val;
  logic signed [63:0] term;
  logic [1:0]         steps;
  logic [1:0]         step;
  logic signed [63:0] acc;
  logic               clip;
  logic signed [32:0] mul_a;
  logic signed [64:0] mul_p;
  logic signed [64:0] p_lo;
  logic signed [64:0] p_hi;
  logic signed [95:0] prod_q;
  logic signed [95:0] sh;
  logic               fits;
  logic signed [63:0] mv;
  logic [64:0]        sum65;
  logic               ovf;
  logic signed [63:0] add_res;
  logic               res_sat;
  logic signed [63:0] res_val;

  assign job_pop = (state == B_IDLE) && !job_empty;

  // Coefficients enter as Q24.24 and are widened to Q32.32; the derivative scalings are exact.
  assign a64 = {{8{ca[47]}}, ca, 8'h00};
  assign b64 = {{8{cb[47]}}, cb, 8'h00};
  assign c64 = {{8{cc[47]}}, cc, 8'h00};
  assign d64 = {{8{cd[47]}}, cd, 8'h00};
  assign a3  = (a64 <<< 1) + a64;
  assign a6  = a3 <<< 1;
  assign b2  = b64 <<< 1;

  always_comb begin
    case (order)
      ORD_VALUE: begin
        init_val = a64;
        steps    = 2'd3;
      end
      ORD_D1: begin
        init_val = a3;
        steps    = 2'd2;
      end
      ORD_D2: begin
        init_val = a6;
        steps    = 2'd1;
      end
      ORD_D3: begin
        init_val = a6;
        steps    = 2'd0;
      end
      default: begin
        init_val = '0;
        steps    = 2'd0;
      end
    endcase
  end

  always_comb begin
    if (step == 2'd0) begin
      term = (order == ORD_VALUE) ? b64 : b2;
    end else if (step == 2'd1) begin
      term = c64;
    end else begin
      term = d64;
    end
  end

  // One 33x32 multiplier handles the accumulator in two halves.
  assign mul_a = (state == B_MUL_LO) ? {1'b0, acc[31:0]} : {acc[63], acc[63:32]};
  assign mul_p = mul_a * x_q;

  // Arithmetic shift of the exact product gives floor rounding.
  assign sh    = prod_q >>> POS_FRAC_BITS;
  assign fits  = (&sh[95:63]) || !(|sh[95:63]);
  assign mv    = fits ? sh[63:0] : (sh[95] ? SAT_MIN : SAT_MAX);
  assign sum65 = {mv[63], mv} + {term[63], term};
  assign ovf   = (sum65[64] != sum65[63]);
  assign add_res = ovf ? (mv[63] ? SAT_MIN : SAT_MAX) : $signed(sum65[63:0]);

  always_ff @(posedge clk) begin
    if (job_pop) begin
      if (job.is_eval) begin
        ca <= cubic_mem[job.index[SW-1:0]];
        cb <= square_mem[job.index[SW-1:0]];
        cc <= linear_mem[job.index[SW-1:0]];
        cd <= constant_mem[job.index[SW-1:0]];
      end else begin
        cubic_mem[job.index[SW-1:0]]    <= job.cubic_coeff;
        square_mem[job.index[SW-1:0]]   <= job.square_coeff;
        linear_mem[job.index[SW-1:0]]   <= job.linear_coeff;
        constant_mem[job.index[SW-1:0]] <= job.constant_coeff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (job_pop && job.is_eval) begin
            state <= B_INIT;
          end
        end
        B_INIT: begin
          if (steps == 2'd0) begin
            done  <= 1'b1;
            state <= B_IDLE;
          end else begin
            state <= B_MUL_LO;
          end
        end
        B_MUL_LO: begin
          state <= B_MUL_HI;
        end
        B_MUL_HI: begin
          state <= B_SUM;
        end
        B_SUM: begin
          state <= B_ADD;
        end
        B_ADD: begin
          if (step == steps - 2'd1) begin
            done  <= 1'b1;
            state <= B_IDLE;
          end else begin
            state <= B_MUL_LO;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_pop && job.is_eval) begin
          x_q   <= job.position;
          order <= job.deriv_order;
          seg_q <= job.index[5:0];
        end
      end
      B_INIT: begin
        acc     <= init_val;
        clip    <= 1'b0;
        step    <= 2'd0;
        res_val <= init_val;
        res_sat <= 1'b0;
      end
      B_MUL_LO: begin
        p_lo <= mul_p;
      end
      B_MUL_HI: begin
        p_hi <= mul_p;
      end
      B_SUM: begin
        prod_q <= (96'(p_hi) <<< 32) + 96'(p_lo);
      end
      B_ADD: begin
        acc     <= add_res;
        clip    <= clip || !fits || ovf;
        step    <= step + 2'd1;
        res_val <= add_res;
        res_sat <= clip || !fits || ovf;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign result.result_value = res_val;
  assign result.segment_used = seg_q;
  assign result.saturated    = res_sat;

endmodule

[rtl/cubic_spline_evaluator.sv]
// Load: accepted when idle; busy stays high in the hand-off state while its coefficients
// wait for room in the queue. Evaluate: busy through the knot scan, which stops at the
// first knot above the point, or at the segment count if none, and through the hand-off;
// the back end then fetches the coefficients and runs s multiply-adds (3, 2, 1, 0), each
// a low and a high multiply, a sum and an add; a 2-entry queue overlaps the two. Strobes
// last one cycle and cannot be stalled; reset keeps the tables, segment_count is 1.
module cubic_spline_evaluator #(
  parameter int MAX_SEGMENTS  = 64,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  cse_pkg::cse_in_t           cmd,
  output logic                       busy,
  output logic                       done,
  output cse_pkg::cse_out_t          result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cse_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cse_pkg::*;

  logic       [6:0] seg_count;
  logic             cfg_wr;
  logic             job_push;
  logic             job_full;
  logic             job_pop;
  logic             job_empty;
  cse_job_t         push_job;
  cse_job_t         pop_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SEG_COUNT);
  assign prdata = (paddr[ADDR_W-1] == REG_SEG_COUNT) ? {25'd0, seg_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= 7'd1;
    end else if (cfg_wr) begin
      seg_count <= pwdata[6:0];
    end
  end

  cse_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .seg_count (seg_count),
    .job_push  (job_push),
    .job       (push_job),
    .job_full  (job_full)
  );

  cse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .empty    (job_empty)
  );

  cse_back #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (pop_job),
    .job_pop   (job_pop),
    .done      (done),
    .result    (result)
  );

endmodule

[rtl/cse_checker.sv]
module cse_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input cse_pkg::cse_in_t cmd,
  input logic             busy,
  input logic             done
);
  import cse_pkg::*;

  // Nothing is in flight right after reset.
  assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

  // An accepted evaluate always occupies the knot scan.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.opcode == OP_EVAL)) |=> busy)
    else $error("evaluate accepted without entering the knot scan");

  // Each evaluation yields one strobe; two in a row would mean a duplicate result.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

endmodule

bind cubic_spline_evaluator cse_checker u_cse_checker (.*);

[tb/cubic_spline_evaluator_checker.sv]
module cubic_spline_evaluator_checker
  import cse_pkg::*;
#(
  parameter int MAX_SEGMENTS  = 64,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  cse_in_t           cmd,
  input  logic              done,
  input  cse_out_t          result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  output int                fail_count,
  output int                results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] knot_mem     [0:MAX_SEGMENTS];
  logic signed [47:0] cubic_mem    [0:MAX_SEGMENTS-1];
  logic signed [47:0] square_mem   [0:MAX_SEGMENTS-1];
  logic signed [47:0] linear_mem   [0:MAX_SEGMENTS-1];
  logic signed [47:0] constant_mem [0:MAX_SEGMENTS-1];
  logic [6:0]         seg_count;
  cse_out_t           spline_results_q [$];
  int                 mismatches = 0;

  function automatic int active_segments();
    int n;
    n = seg_count;
    if (n < 1) n = 1;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    return n;
  endfunction

  // Upper-bound scan: the first used knot above x closes the segment.
  function automatic int locate_segment(logic signed [31:0] x, int n);
    for (int i = 0; i <= n; i++) begin
      if (knot_mem[i] > x) return (i == 0) ? 0 : i - 1;
    end
    return n - 1;
  endfunction

  // One Horner step: acc * x floored back to Q32.32, clipped, then term added with clipping.
  function automatic logic signed [63:0] horner_step(logic signed [63:0] acc,
                                                     logic signed [31:0] x,
                                                     logic signed [63:0] term,
                                                     inout logic clipped);
    logic signed [95:0] prod;
    logic signed [63:0] scaled;
    logic signed [64:0] sum;
    prod = acc * x;
    prod = prod >>> POS_FRAC_BITS;
    if (prod[95:63] != {33{prod[63]}}) begin
      clipped = 1'b1;
      scaled = prod[95] ? SAT_MIN : SAT_MAX;
    end else begin
      scaled = prod[63:0];
    end
    sum = scaled + term;
    if (sum[64] != sum[63]) begin
      clipped = 1'b1;
      return sum[64] ? SAT_MIN : SAT_MAX;
    end
    return sum[63:0];
  endfunction

  function automatic cse_out_t predict_spline(logic signed [31:0] x, logic [2:0] order);
    cse_out_t           r;
    int                 seg;
    logic signed [63:0] a, b, c, d, acc;
    logic               clipped;
    seg = locate_segment(x, active_segments());
    // Coefficients move from Q24.24 to Q32.32.
    a = cubic_mem[seg];
    b = square_mem[seg];
    c = linear_mem[seg];
    d = constant_mem[seg];
    a = a <<< 8;
    b = b <<< 8;
    c = c <<< 8;
    d = d <<< 8;
    clipped = 1'b0;
    case (order)
      ORD_VALUE: begin
        acc = horner_step(a, x, b, clipped);
        acc = horner_step(acc, x, c, clipped);
        acc = horner_step(acc, x, d, clipped);
      end
      ORD_D1: begin
        acc = horner_step(a * 3, x, b * 2, clipped);
        acc = horner_step(acc, x, c, clipped);
      end
      ORD_D2: acc = horner_step(a * 6, x, b * 2, clipped);
      ORD_D3: acc = a * 6;
      default: acc = '0;
    endcase
    r.result_value = acc;
    r.segment_used = seg[5:0];
    r.saturated    = clipped;
    return r;
  endfunction

  always @(posedge clk) begin
    cse_out_t want;
    int       n;
    if (rst) begin
      seg_count = 7'd1;
      spline_results_q.delete();
    end else begin
      if (done) begin
        if (spline_results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: value=%h segment=%0d sat=%b",
                   $time, result.result_value, result.segment_used, result.saturated);
          mismatches++;
        end else begin
          want = spline_results_q.pop_front();
          if (result.result_value !== want.result_value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     want.result_value, result.result_value);
            mismatches++;
          end
          if (result.segment_used !== want.segment_used) begin
            $display("%0t: segment_used expected %0d actual %0d", $time,
                     want.segment_used, result.segment_used);
            mismatches++;
          end
          if (result.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     want.saturated, result.saturated);
            mismatches++;
          end
        end
      end

      if (psel && penable && pready && paddr[ADDR_W-1] == REG_SEG_COUNT) begin
        if (pwrite) begin
          seg_count = pwdata[6:0];
        end else if (prdata[6:0] !== seg_count) begin
          $display("%0t: segment_count read expected %0d actual %0d", $time,
                   seg_count, prdata[6:0]);
          mismatches++;
        end
      end

      if (start && !busy) begin
        if (cmd.opcode == OP_LOAD) begin
          n = active_segments();
          if (cmd.entry_index <= MAX_SEGMENTS) knot_mem[cmd.entry_index] = cmd.knot_position;
          // The entry that closes the last segment carries a knot only.
          if (cmd.entry_index < MAX_SEGMENTS && cmd.entry_index != n) begin
            cubic_mem[cmd.entry_index]    = cmd.cubic_coeff;
            square_mem[cmd.entry_index]   = cmd.square_coeff;
            linear_mem[cmd.entry_index]   = cmd.linear_coeff;
            constant_mem[cmd.entry_index] = cmd.constant_coeff;
          end
        end else begin
          spline_results_q = {spline_results_q,
                              predict_spline(cmd.eval_position, cmd.deriv_order)};
        end
      end
    end
    fail_count          <= mismatches;
    results_outstanding <= spline_results_q.size();
  end

endmodule

[tb/cubic_spline_evaluator_tb.sv]
module cubic_spline_evaluator_tb
  import cse_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG   = 64;
  localparam int SETTLE = 100;
  localparam logic [ADDR_W-1:0] SEG_COUNT_ADDR = {REG_SEG_COUNT, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR     = {~REG_SEG_COUNT, 2'b00};
  // Orders above the third derivative read back as zero.
  localparam logic [2:0] ORD_D4 = 3'd4;
  localparam logic [2:0] ORD_D5 = 3'd5;
  localparam logic [2:0] ORD_D6 = 3'd6;
  localparam logic [2:0] ORD_D7 = 3'd7;
  localparam int PLAN_LEN = 8;
  localparam logic [6:0] COUNT_PLAN [PLAN_LEN] =
    '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd3, 7'd12, 7'd33};

  logic              clk;
  logic              rst;
  logic              start;
  cse_in_t           cmd;
  logic              busy;
  logic              done;
  cse_out_t          result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                results_outstanding;

  logic signed [31:0] knot_copy [0:NSEG];
  int                 seg_total;
  int                 loads_sent;
  int                 evals_sent;
  int                 settings_used;
  bit                 burst;

  cubic_spline_evaluator i_dut (
    .clk, .rst, .start, .cmd, .busy, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cubic_spline_evaluator_checker i_checker (
    .clk, .rst, .start, .busy, .cmd, .done, .result,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .prdata,
    .fail_count, .results_outstanding
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic signed [47:0] pick_coeff();
    logic signed [47:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1: ;
      2: v = '0;
      3: v = $urandom_range(0, 1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
      default: v = v >>> $urandom_range(8, 40);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_pos(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic cse_in_t random_fields();
    cse_in_t item;
    item.opcode         = OP_EVAL;
    item.entry_index    = 7'($urandom);
    item.knot_position  = $urandom;
    item.cubic_coeff    = pick_coeff();
    item.square_coeff   = pick_coeff();
    item.linear_coeff   = pick_coeff();
    item.constant_coeff = pick_coeff();
    item.eval_position  = $urandom;
    item.deriv_order    = 3'($urandom);
    return item;
  endfunction

  function automatic cse_in_t make_load(int idx, logic signed [31:0] knot);
    cse_in_t item;
    item = random_fields();
    item.opcode        = OP_LOAD;
    item.entry_index   = idx[6:0];
    item.knot_position = knot;
    return item;
  endfunction

  function automatic cse_in_t make_eval(logic signed [31:0] x, logic [2:0] order);
    cse_in_t item;
    item = random_fields();
    item.opcode        = OP_EVAL;
    item.eval_position = x;
    item.deriv_order   = order;
    return item;
  endfunction

  function automatic logic signed [31:0] pick_position();
    int     i, j;
    longint lo, hi;
    i = $urandom_range(0, seg_total);
    j = $urandom_range(0, seg_total - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return clamp_pos(longint'(knot_copy[i]) + longint'($urandom_range(0, 6)) - 3);
      4, 5, 6: begin
        lo = knot_copy[j];
        hi = knot_copy[j + 1];
        if (hi > lo) return clamp_pos(lo + longint'($urandom) % (hi - lo));
        return clamp_pos(lo);
      end
      7: begin
        if ($urandom_range(0, 1))
          return clamp_pos(longint'(knot_copy[0]) - 1 - longint'($urandom_range(0, 1000)));
        return clamp_pos(longint'(knot_copy[seg_total]) + longint'($urandom_range(0, 1000)));
      end
      8: return $urandom;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the beat has been accepted and busy is low.
  task automatic send_item(cse_in_t item);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (item.opcode == OP_LOAD) begin
      loads_sent++;
      if (item.entry_index <= NSEG) knot_copy[item.entry_index] = item.knot_position;
    end else begin
      evals_sent++;
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  task automatic apb_access(logic write, logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_segments(logic [6:0] value);
    logic [31:0] data;
    // Loads leave no result behind, so give the back end time to retire them.
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    data = $urandom;
    data[6:0] = value;
    apb_access(1'b1, SEG_COUNT_ADDR, data);
    apb_access(1'b0, SEG_COUNT_ADDR, '0);
    seg_total = (value == 0) ? 1 : (value > NSEG) ? NSEG : value;
    settings_used++;
  endtask

  task automatic load_table(bit scrambled);
    longint k;
    int     shift;
    shift = $urandom_range(0, 14);
    k = longint'($signed($urandom)) >>> (shift + 1);
    for (int i = 0; i <= seg_total; i++) begin
      if (scrambled) send_item(make_load(i, $signed($urandom) >>> shift));
      else send_item(make_load(i, clamp_pos(k)));
      k += $urandom_range(1, 1 << $urandom_range(2, 22 - shift));
    end
  endtask

  task automatic run_directed();
    logic signed [31:0] probe_x [14] = '{
      32'sh8000_0000, 32'shFFFD_0000, 32'shFFFE_0000, 32'shFFFF_0000, 32'sh0000_0000,
      32'sh0000_8000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0003_8000,
      32'sh0004_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0003_4000};
    logic [2:0] probe_order [14] = '{
      ORD_VALUE, ORD_D1, ORD_D2, ORD_VALUE, ORD_VALUE, ORD_D3, ORD_VALUE, ORD_D1,
      ORD_D4, ORD_D5, ORD_VALUE, ORD_D7, ORD_VALUE, ORD_D6};
    cse_in_t item;
    set_segments(7'd4);
    // Writes to the spare word must leave segment_count alone.
    apb_access(1'b1, SPARE_ADDR, $urandom);
    apb_access(1'b0, SEG_COUNT_ADDR, '0);

    item = make_load(0, 32'shFFFE_0000);
    item.cubic_coeff    = 48'sh0000_0100_0000;
    item.square_coeff   = 48'shFFFF_FE00_0000;
    item.linear_coeff   = 48'sh0000_0300_0000;
    item.constant_coeff = 48'shFFFF_FB00_0000;
    send_item(item);
    item = make_load(1, 32'sh0000_0000);
    item.cubic_coeff    = 48'sh7FFF_FFFF_FFFF;
    item.square_coeff   = 48'sh7FFF_FFFF_FFFF;
    item.linear_coeff   = 48'sh7FFF_FFFF_FFFF;
    item.constant_coeff = 48'sh7FFF_FFFF_FFFF;
    send_item(item);
    item = make_load(2, 32'sh0001_0000);
    item.cubic_coeff    = 48'sh8000_0000_0000;
    item.square_coeff   = 48'sh8000_0000_0000;
    item.linear_coeff   = 48'sh8000_0000_0000;
    item.constant_coeff = 48'sh8000_0000_0000;
    send_item(item);
    send_item(make_load(3, 32'sh0003_0000));
    // The closing knot's coefficients are dropped; indexes past the table are ignored.
    send_item(make_load(4, 32'sh0004_0000));
    send_item(make_load(64, $urandom));
    send_item(make_load(65, $urandom));
    send_item(make_load(127, $urandom));
    for (int i = 0; i < 14; i++) send_item(make_eval(probe_x[i], probe_order[i]));
  endtask

  task automatic random_traffic(int count);
    cse_in_t item;
    int      idx;
    repeat (count) begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      if ($urandom_range(0, 39) == 0) wait_for_results();
      if ($urandom_range(0, 9) < 7) begin
        item = make_eval(pick_position(), 3'($urandom_range(0, 7)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: idx = $urandom_range(0, seg_total - 1);
          6, 7: idx = seg_total;
          default: idx = $urandom_range(seg_total + 1, 127);
        endcase
        // Most rewrites keep the knot so the table stays sorted.
        if (idx <= seg_total && $urandom_range(0, 4) != 0) item = make_load(idx, knot_copy[idx]);
        else item = make_load(idx, $urandom);
      end
      send_item(item);
    end
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    cmd     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    burst   = 1'b0;
    seg_total     = 1;
    loads_sent    = 0;
    evals_sent    = 0;
    settings_used = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (int p = 0; p < PLAN_LEN + 2; p++) begin
      set_segments(p < PLAN_LEN ? COUNT_PLAN[p] : 7'($urandom_range(1, 40)));
      load_table(p == 5);
      random_traffic(20);
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d loads and %0d evaluations across %0d segment-count settings,",
             loads_sent, evals_sent, settings_used);
    $display("including counts 0, 1, 64 and 127, an unsorted knot table and orders 0 to 7.");
    if (fail_count == 0 && results_outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cse_pkg.sv
rtl/cse_front.sv
rtl/cse_queue.sv
rtl/cse_back.sv
rtl/cubic_spline_evaluator.sv
rtl/cse_checker.sv
tb/cubic_spline_evaluator_checker.sv
tb/cubic_spline_evaluator_tb.sv
